[rtl/core/bvm_pkg.sv]
// Shared types and constants for the battery voltage monitor.
`timescale 1ns / 1ps

package bvm_pkg;

    // Block constants
    localparam int SETTLE_SAMPLES = 100;
    localparam int MAX_CELLS      = 6;
    localparam int CELL_LIMIT     = 7;
    localparam int CELL_LO_MV     = 3300;
    localparam int CELL_HI_MV     = 4300;
    localparam int NO_BATT_Q8     = 5000 * 256;
    localparam int FILT_MAX       = 65535 * 256;
    localparam int ADC_FULL_SCALE = 4095;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TAU    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_REF       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER_RATIO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_CELL     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CRIT_CELL     = 3'd6;

    // Status codes
    localparam logic [1:0] ST_NO_BATT = 2'd0;
    localparam logic [1:0] ST_OK      = 2'd1;
    localparam logic [1:0] ST_WARN    = 2'd2;
    localparam logic [1:0] ST_CRIT    = 2'd3;

    // Shared multiply/divide unit
    localparam int MDU_W  = 64;
    localparam int MDU_DW = 33;
    localparam int MDU_CW = 7;

    typedef enum logic {
        MDU_MUL,
        MDU_DIV
    } t_mdu_op;

    typedef struct packed {
        logic              start;
        t_mdu_op           op;
        logic [MDU_W-1:0]  a;
        logic [MDU_DW-1:0] b;
        logic [MDU_CW-1:0] nbits;
    } t_mdu_cmd;

    typedef struct packed {
        logic             done;
        logic [MDU_W-1:0] result;
    } t_mdu_rsp;

    typedef struct packed {
        logic [15:0] elapsed_us;
        logic [11:0] adc_sample;
        logic        adc_ok;
    } t_in;

    typedef struct packed {
        logic [15:0] pack_mv;
        logic [2:0]  cell_count;
        logic [15:0] cell_mv;
        logic [1:0]  status;
        logic        sampled;
    } t_out;

endpackage

[rtl/core/battery_voltage_monitor.sv]
// Top level: tick accumulation, sample scaling, low-pass filter, cell detection.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_stall    i_in  (t_in)
// out       output     o_out_valid / i_out_stall  o_out (t_out)
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A tick that takes no sample goes from idle through S_FIN to the output register.
// A sampled tick runs up to six serial multiply/divide passes on one shared
// unit, of n = 13, 16, 18, 24, 56, 16 bits, and divides the scaled product by
// 4095 by folding; the filter passes are skipped when tau and step are both
// zero. o_in_stall is high until the result is loaded; a stalled result
// holds while the next transaction is accepted.
// Reset is synchronous; configuration registers return to their defaults.

module battery_voltage_monitor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  bvm_pkg::t_in                        i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output bvm_pkg::t_out                       o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bvm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bvm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import bvm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_REF,
        S_MUL_RATIO,
        S_MUL_GAIN,
        S_DIV_SCALE,
        S_MUL_FILT,
        S_DIV_FILT,
        S_EVAL,
        S_RATE,
        S_DIV_CELL,
        S_FIN
    } t_state;

    // Configuration
    logic [19:0] r_period;
    logic [23:0] r_tau;
    logic [12:0] r_ref;
    logic [15:0] r_ratio;
    logic [17:0] r_gain;
    logic [12:0] r_warn;
    logic [12:0] r_crit;

    // Sequencer and block state
    t_state      r_state;
    logic        r_wait;
    logic [31:0] r_acc;
    logic [23:0] r_filt;
    logic [2:0]  r_cells;
    logic [7:0]  r_settle;
    logic [1:0]  r_status;
    logic [15:0] r_cell_mv;
    logic        r_out_valid;
    t_out        r_out;

    // Per-item working registers
    logic [31:0]      r_step;
    logic [11:0]      r_raw;
    logic             r_took;
    logic [MDU_W-1:0] r_prod;
    logic [23:0]      r_v;
    logic             r_up;
    logic [42:0]      r_fold;
    logic [31:0]      r_quo;

    t_mdu_cmd    mdu_cmd;
    t_mdu_rsp    mdu_rsp;

    logic        in_acc;
    logic        out_free;
    logic [32:0] n_sum;
    logic [31:0] n_acc;
    logic        n_take;
    logic [32:0] n_den;
    logic        n_bypass;
    logic [23:0] n_d;
    logic [31:0] n_quo;
    logic [23:0] n_v;
    logic [2:0]  n_found;
    logic [15:0] n_crit_mul;
    logic [15:0] n_warn_mul;
    logic [15:0] n_pack;

    bvm_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mdu_cmd),
        .o_rsp   (mdu_rsp)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_sum    = {1'b0, r_acc} + 33'(i_in.elapsed_us);
        n_acc    = n_sum[32] ? '1 : n_sum[31:0];
        n_take   = n_acc >= 32'(r_period);
        n_den    = 33'(r_tau) + 33'(r_step);
        n_bypass = (r_tau == '0) && (r_step == '0);
        n_d      = (r_v >= r_filt) ? (r_v - r_filt) : (r_filt - r_v);
        // the folded remainder is below 4096, so only 4095 itself adds one
        n_quo    = r_quo + {31'b0, (r_fold == 43'(ADC_FULL_SCALE))};
        n_v      = (n_quo > 32'(FILT_MAX)) ? 24'(FILT_MAX) : n_quo[23:0];
        n_pack   = r_filt[23:8];
        n_crit_mul = 16'(16'(r_crit) * 16'(r_cells));
        n_warn_mul = 16'(16'(r_warn) * 16'(r_cells));
    end

    // Smallest cell count whose per-cell voltage lies in the Li-ion window
    always_comb begin
        n_found = '0;
        for (int c = CELL_LIMIT; c >= 2; c--) begin
            if (c <= MAX_CELLS &&
                {3'b0, r_filt} >= 27'(CELL_LO_MV * 256 * c) &&
                {3'b0, r_filt} <= 27'(CELL_HI_MV * 256 * c)) begin
                n_found = 3'(c);
            end
        end
    end

    always_comb begin
        mdu_cmd       = '0;
        mdu_cmd.op    = MDU_MUL;
        case (r_state)
            S_MUL_REF: begin
                mdu_cmd.a     = MDU_W'(r_raw);
                mdu_cmd.b     = MDU_DW'(r_ref);
                mdu_cmd.nbits = MDU_CW'(13);
            end
            S_MUL_RATIO: begin
                mdu_cmd.a     = r_prod;
                mdu_cmd.b     = MDU_DW'(r_ratio);
                mdu_cmd.nbits = MDU_CW'(16);
            end
            S_MUL_GAIN: begin
                mdu_cmd.a     = r_prod;
                mdu_cmd.b     = MDU_DW'(r_gain);
                mdu_cmd.nbits = MDU_CW'(18);
            end
            S_MUL_FILT: begin
                mdu_cmd.a     = MDU_W'(r_step);
                mdu_cmd.b     = MDU_DW'(n_d);
                mdu_cmd.nbits = MDU_CW'(24);
            end
            S_DIV_FILT: begin
                mdu_cmd.op    = MDU_DIV;
                mdu_cmd.a     = {r_prod[55:0], 8'b0};
                mdu_cmd.b     = n_den;
                mdu_cmd.nbits = MDU_CW'(56);
            end
            S_DIV_CELL: begin
                mdu_cmd.op    = MDU_DIV;
                mdu_cmd.a     = {n_pack, 48'b0};
                mdu_cmd.b     = MDU_DW'(r_cells);
                mdu_cmd.nbits = MDU_CW'(16);
            end
            default: begin
                mdu_cmd.nbits = '0;
            end
        endcase
        mdu_cmd.start = !r_wait &&
                        (r_state == S_MUL_REF   || r_state == S_MUL_RATIO ||
                         r_state == S_MUL_GAIN  ||
                         r_state == S_MUL_FILT  || r_state == S_DIV_FILT  ||
                         (r_state == S_DIV_CELL && r_cells != '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 20'd10000;
            r_tau    <= 24'd500000;
            r_ref    <= 13'd3300;
            r_ratio  <= 16'd2816;
            r_gain   <= 18'd65536;
            r_warn   <= 13'd3500;
            r_crit   <= 13'd3300;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SAMPLE_PERIOD: r_period <= i_cfg_data[19:0];
                CFG_FILTER_TAU:    r_tau    <= i_cfg_data[23:0];
                CFG_ADC_REF:       r_ref    <= i_cfg_data[12:0];
                CFG_DIVIDER_RATIO: r_ratio  <= i_cfg_data[15:0];
                CFG_GAIN:          r_gain   <= i_cfg_data[17:0];
                CFG_WARN_CELL:     r_warn   <= i_cfg_data[12:0];
                CFG_CRIT_CELL:     r_crit   <= i_cfg_data[12:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_acc       <= '0;
            r_filt      <= '0;
            r_cells     <= '0;
            r_settle    <= '0;
            r_status    <= ST_NO_BATT;
            r_cell_mv   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (mdu_cmd.start) begin
                r_wait <= 1'b1;
            end
            if (mdu_rsp.done) begin
                r_wait <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_step  <= n_acc;
                        r_acc   <= n_take ? '0 : n_acc;
                        r_raw   <= i_in.adc_sample;
                        r_took  <= n_take && i_in.adc_ok;
                        r_state <= (n_take && i_in.adc_ok) ? S_MUL_REF : S_FIN;
                    end
                end
                S_MUL_REF: begin
                    if (mdu_rsp.done) begin
                        r_prod  <= mdu_rsp.result;
                        r_state <= S_MUL_RATIO;
                    end
                end
                S_MUL_RATIO: begin
                    if (mdu_rsp.done) begin
                        r_prod  <= mdu_rsp.result;
                        r_state <= S_MUL_GAIN;
                    end
                end
                S_MUL_GAIN: begin
                    if (mdu_rsp.done) begin
                        // start (p >> 16) / 4095
                        r_fold  <= mdu_rsp.result[58:16];
                        r_quo   <= '0;
                        r_state <= S_DIV_SCALE;
                    end
                end
                S_DIV_SCALE: begin
                    if (r_fold[42:12] != '0) begin
                        // x = 4096a + b = 4095a + (a + b): bank a, fold into a + b
                        r_quo  <= r_quo + 32'(r_fold[42:12]);
                        r_fold <= 43'(r_fold[42:12]) + 43'(r_fold[11:0]);
                    end else begin
                        r_v <= n_v;
                        if (n_bypass) begin
                            // alpha is one: take the sample directly
                            r_filt  <= n_v;
                            r_state <= S_EVAL;
                        end else begin
                            r_state <= S_MUL_FILT;
                        end
                    end
                end
                S_MUL_FILT: begin
                    if (mdu_cmd.start) begin
                        r_up <= (r_v >= r_filt);
                    end
                    if (mdu_rsp.done) begin
                        r_prod  <= mdu_rsp.result;
                        r_state <= S_DIV_FILT;
                    end
                end
                S_DIV_FILT: begin
                    if (mdu_rsp.done) begin
                        r_filt  <= r_up ? (r_filt + mdu_rsp.result[23:0])
                                        : (r_filt - mdu_rsp.result[23:0]);
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if ({3'b0, r_filt} < 27'(NO_BATT_Q8)) begin
                        r_cells  <= '0;
                        r_status <= ST_NO_BATT;
                        r_settle <= '0;
                        r_state  <= S_DIV_CELL;
                    end else if (r_cells != '0) begin
                        r_state  <= S_RATE;
                    end else if (r_settle < 8'(SETTLE_SAMPLES)) begin
                        r_settle <= r_settle + 1'b1;
                        r_state  <= S_DIV_CELL;
                    end else begin
                        // with no fit, count stays zero and status holds
                        r_cells  <= n_found;
                        r_state  <= (n_found != '0) ? S_RATE : S_DIV_CELL;
                    end
                end
                S_RATE: begin
                    if (r_filt < {n_crit_mul, 8'b0}) begin
                        r_status <= ST_CRIT;
                    end else if (r_filt < {n_warn_mul, 8'b0}) begin
                        r_status <= ST_WARN;
                    end else begin
                        r_status <= ST_OK;
                    end
                    r_state <= S_DIV_CELL;
                end
                S_DIV_CELL: begin
                    if (r_cells == '0) begin
                        r_cell_mv <= '0;
                        r_state   <= S_FIN;
                    end else if (mdu_rsp.done) begin
                        r_cell_mv <= mdu_rsp.result[15:0];
                        r_state   <= S_FIN;
                    end
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_out.pack_mv    <= n_pack;
                        r_out.cell_count <= r_cells;
                        r_out.cell_mv    <= r_cell_mv;
                        r_out.status     <= r_status;
                        r_out.sampled    <= r_took;
                        r_out_valid      <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/core/bvm_mdu.sv]
// Bit-serial multiply (shift-add) and restoring divide unit.
`timescale 1ns / 1ps

module bvm_mdu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bvm_pkg::t_mdu_cmd i_cmd,
    output bvm_pkg::t_mdu_rsp o_rsp
);
    import bvm_pkg::*;

    logic              r_busy;
    logic              r_done;
    t_mdu_op           r_op;
    logic [MDU_CW-1:0] r_cnt;
    logic [MDU_W-1:0]  r_x;    // multiplicand, or dividend/quotient shifter
    logic [MDU_DW-1:0] r_y;    // multiplier, or divisor
    logic [MDU_W-1:0]  r_z;    // product accumulator, or remainder

    logic [MDU_DW:0]   n_trial;
    logic              n_fits;
    logic [MDU_DW:0]   n_diff;

    always_comb begin
        n_trial = {r_z[MDU_DW-1:0], r_x[MDU_W-1]};
        n_fits  = n_trial >= {1'b0, r_y};
        n_diff  = n_trial - {1'b0, r_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_op   <= i_cmd.op;
                r_cnt  <= i_cmd.nbits;
                r_x    <= i_cmd.a;
                r_y    <= i_cmd.b;
                r_z    <= '0;
            end else if (r_busy) begin
                if (r_op == MDU_MUL) begin
                    if (r_y[0]) begin
                        r_z <= r_z + r_x;
                    end
                    r_x <= {r_x[MDU_W-2:0], 1'b0};
                    r_y <= {1'b0, r_y[MDU_DW-1:1]};
                end else begin
                    // remainder stays below the divisor, so 33 bits hold it
                    r_z <= MDU_W'(n_fits ? n_diff[MDU_DW-1:0] : n_trial[MDU_DW-1:0]);
                    r_x <= {r_x[MDU_W-2:0], n_fits};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == MDU_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = (r_op == MDU_MUL) ? r_z : r_x;

endmodule
